@@ rtl/text_console_glyph_renderer_assert.svh @@
// ----------------------------------------------------------------------------
// text console glyph renderer assertion macros
// shared property forms for the renderer rtl
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

// same-cycle implication
`define TCGR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCGR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tcgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcgr_pkg
// types and constants shared by the text console glyph renderer
// ----------------------------------------------------------------------------
`default_nettype none

package tcgr_pkg;

   localparam int GLYPH_COLUMNS = 8;

   localparam int COLOR_W     = 32;
   localparam int STRIDE_W    = 14;
   localparam int SCREEN_W    = 13;
   localparam int ADVANCE_W   = 5;
   localparam int ROWS_W      = 5;
   localparam int CURSOR_W    = 16;
   localparam int OFFSET_W    = 26;
   localparam int CODE_W      = 8;
   localparam int FONT_ROW_W  = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CODE_W-1:0] CODE_BS  = 8'h08;
   localparam logic [CODE_W-1:0] CODE_TAB = 8'h09;
   localparam logic [CODE_W-1:0] CODE_LF  = 8'h0A;
   localparam logic [CODE_W-1:0] CODE_CR  = 8'h0D;

   localparam logic [COLOR_W-1:0]   RST_TEXT_COLOR    = 32'hFFFF_FFFF;
   localparam logic [STRIDE_W-1:0]  RST_LINE_STRIDE   = 14'd1024;
   localparam logic [SCREEN_W-1:0]  RST_SCREEN_WIDTH  = 13'd1024;
   localparam logic [SCREEN_W-1:0]  RST_SCREEN_HEIGHT = 13'd768;
   localparam logic [ADVANCE_W-1:0] RST_GLYPH_ADVANCE = 5'd8;
   localparam logic [ROWS_W-1:0]    RST_GLYPH_ROWS    = 5'd16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEXT_COLOR,
      CSR_LINE_STRIDE,
      CSR_SCREEN_WIDTH,
      CSR_SCREEN_HEIGHT,
      CSR_GLYPH_ADVANCE,
      CSR_GLYPH_ROWS
   } tcgr_csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BASE,
      S_CURS,
      S_ROWS,
      S_CLEAR
   } tcgr_state_type;

endpackage

`default_nettype wire

@@ rtl/tcgr_req_if.sv @@
// ----------------------------------------------------------------------------
// tcgr_req_if
// request channel: one character or one font row load per request
// ----------------------------------------------------------------------------
`default_nettype none

interface tcgr_req_if import tcgr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [CODE_W-1:0]     char_code;
   logic [FONT_ROW_W-1:0] font_row;
   logic [GLYPH_COLUMNS-1:0] font_bits;
   logic                  end_of_string;

   modport source (output valid, mode, char_code, font_row, font_bits, end_of_string,
                   input ready);
   modport sink (input valid, mode, char_code, font_row, font_bits, end_of_string,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/tcgr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tcgr_rsp_if
// result channel: one glyph row write or one clear request per item
// ----------------------------------------------------------------------------
`default_nettype none

interface tcgr_rsp_if import tcgr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OFFSET_W-1:0]      pixel_offset;
   logic [GLYPH_COLUMNS-1:0] row_mask;
   logic [COLOR_W-1:0]       pixel_color;
   logic                     clear_screen;
   logic                     last;

   modport source (output valid, pixel_offset, row_mask, pixel_color, clear_screen, last,
                   input ready);
   modport sink (input valid, pixel_offset, row_mask, pixel_color, clear_screen, last,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/tcgr_font_ram.sv @@
// ----------------------------------------------------------------------------
// tcgr_font_ram
// font bitmap store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_font_ram import tcgr_pkg::*; #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [GLYPH_COLUMNS-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output      logic [GLYPH_COLUMNS-1:0] rd_data_ff
);

   logic [GLYPH_COLUMNS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/text_console_glyph_renderer.sv @@
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Bitmap font text console: each request is a character to print or one font
// row to load. A font load gives no result. A printable character passes
// through accept, base offset multiply and cursor update, then gives one result
// per glyph row, plus a clear request when the cursor runs off the bottom.
// Control codes pass through the same accept, multiply and update steps, with
// a clear request when the cursor runs off the bottom. The glyph row rate is
// set by the single read port of the font RAM, one row a cycle; a stall on the
// result side holds the row sequencer. The result register lets the next
// request in while the final result still waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_glyph_renderer_assert.svh"

module text_console_glyph_renderer import tcgr_pkg::*; #(
   parameter int MAX_GLYPH_ROWS = 16,
   parameter int GLYPH_COUNT    = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   tcgr_req_if.sink                    req_bus,
   tcgr_rsp_if.source                  rsp_bus,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FONT_DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
   localparam int FONT_AW    = $clog2(FONT_DEPTH);
   localparam int ROW_W      = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
   localparam int HEIGHT_W   = $clog2(MAX_GLYPH_ROWS + 1);

   tcgr_state_type state_ff, state_in;

   logic [COLOR_W-1:0]   text_color_ff, text_color_in;
   logic [STRIDE_W-1:0]  line_stride_ff, line_stride_in;
   logic [SCREEN_W-1:0]  screen_width_ff, screen_width_in;
   logic [SCREEN_W-1:0]  screen_height_ff, screen_height_in;
   logic [ADVANCE_W-1:0] glyph_advance_ff, glyph_advance_in;
   logic [ROWS_W-1:0]    glyph_rows_ff, glyph_rows_in;

   logic [CURSOR_W-1:0] cursor_x_ff, cursor_x_in;
   logic [CURSOR_W-1:0] cursor_y_ff, cursor_y_in;
   logic [CURSOR_W-1:0] x1_ff, x1_in;
   logic [CURSOR_W-1:0] y1_ff, y1_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [CODE_W-1:0]   glyph_ff, glyph_in;
   logic                print_ff, print_in;
   logic                clr_ff, clr_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [ROW_W-1:0]    row_ff, row_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0]      rsp_offset_ff, rsp_offset_in;
   logic [GLYPH_COLUMNS-1:0] rsp_mask_ff, rsp_mask_in;
   logic [COLOR_W-1:0]       rsp_color_ff, rsp_color_in;
   logic                     rsp_clear_ff, rsp_clear_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                           req_accept;
   logic [CODE_W-1:0]              req_glyph;
   logic                           font_wr_en;
   logic [FONT_AW-1:0]             font_wr_addr;
   logic [FONT_AW-1:0]             font_rd_addr;
   logic [GLYPH_COLUMNS-1:0]       font_rd_data_ff;
   logic [HEIGHT_W-1:0]            height;
   logic [CURSOR_W-1:0]            height16;
   logic [CURSOR_W-1:0]            adv16;
   logic [CURSOR_W-1:0]            tab16;
   logic [CURSOR_W+STRIDE_W-1:0]   base_prod;
   logic                           wrap;
   logic [CURSOR_W-1:0]            x2;
   logic [CURSOR_W-1:0]            y2;
   logic                           clear_hit;
   logic                           slot_free;
   logic                           last_row;

   // font store
   tcgr_font_ram #(
      .DEPTH  (FONT_DEPTH),
      .ADDR_W (FONT_AW)
   ) u_font_ram (
      .clock      (clock),
      .wr_en      (font_wr_en),
      .wr_addr    (font_wr_addr),
      .wr_data    (req_bus.font_bits),
      .rd_addr    (font_rd_addr),
      .rd_data_ff (font_rd_data_ff)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign req_glyph     = ({1'b0, req_bus.char_code} >= 9'(GLYPH_COUNT)) ?
                          CODE_W'({1'b0, req_bus.char_code} - 9'(GLYPH_COUNT)) :
                          req_bus.char_code;

   assign font_wr_en   = req_accept && req_bus.mode &&
                         (32'(req_bus.font_row) < MAX_GLYPH_ROWS);
   assign font_wr_addr = FONT_AW'(32'(req_glyph) * MAX_GLYPH_ROWS + 32'(req_bus.font_row));
   assign font_rd_addr = FONT_AW'(32'(glyph_ff) * MAX_GLYPH_ROWS + 32'(row_in));

   assign height   = (32'(glyph_rows_ff) < MAX_GLYPH_ROWS) ? HEIGHT_W'(glyph_rows_ff) :
                     HEIGHT_W'(MAX_GLYPH_ROWS);
   assign height16 = CURSOR_W'(height);
   assign adv16    = CURSOR_W'(glyph_advance_ff);
   assign tab16    = CURSOR_W'({glyph_advance_ff, 1'b0}) + adv16;
   assign base_prod = cursor_y_ff * line_stride_ff;

   assign wrap      = (x1_ff >= CURSOR_W'(screen_width_ff));
   assign x2        = wrap ? '0 : x1_ff;
   assign y2        = wrap ? (y1_ff + height16) : y1_ff;
   assign clear_hit = (y2 >= CURSOR_W'(screen_height_ff));

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign last_row  = ((HEIGHT_W'(row_ff) + HEIGHT_W'(1)) == height);

   always_comb begin
      state_in         = state_ff;
      text_color_in    = text_color_ff;
      line_stride_in   = line_stride_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      glyph_advance_in = glyph_advance_ff;
      glyph_rows_in    = glyph_rows_ff;
      cursor_x_in      = cursor_x_ff;
      cursor_y_in      = cursor_y_ff;
      x1_in            = x1_ff;
      y1_in            = y1_ff;
      code_in          = code_ff;
      glyph_in         = glyph_ff;
      print_in         = print_ff;
      clr_in           = clr_ff;
      off_in           = off_ff;
      row_in           = row_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      rsp_offset_in    = rsp_offset_ff;
      rsp_mask_in      = rsp_mask_ff;
      rsp_color_in     = rsp_color_ff;
      rsp_clear_in     = rsp_clear_ff;
      rsp_last_in      = rsp_last_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_TEXT_COLOR:    text_color_in    = csr_wdata;
            CSR_LINE_STRIDE:   line_stride_in   = csr_wdata[STRIDE_W-1:0];
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata[SCREEN_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata[SCREEN_W-1:0];
            CSR_GLYPH_ADVANCE: glyph_advance_in = csr_wdata[ADVANCE_W-1:0];
            CSR_GLYPH_ROWS:    glyph_rows_in    = csr_wdata[ROWS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept && !req_bus.mode) begin
               code_in  = req_bus.char_code;
               glyph_in = req_glyph;
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            off_in   = base_prod[OFFSET_W-1:0] + OFFSET_W'(cursor_x_ff);
            print_in = 1'b0;
            x1_in    = cursor_x_ff;
            y1_in    = cursor_y_ff;
            case (code_ff)
               CODE_LF: begin
                  x1_in = '0;
                  y1_in = cursor_y_ff + height16;
               end
               CODE_CR: begin
                  x1_in = '0;
               end
               CODE_TAB: begin
                  x1_in = cursor_x_ff + tab16;
               end
               CODE_BS: begin
                  if (cursor_x_ff < adv16) begin
                     x1_in = CURSOR_W'(screen_width_ff) - adv16;
                     y1_in = cursor_y_ff - height16;
                  end else begin
                     x1_in = cursor_x_ff - adv16;
                  end
               end
               default: begin
                  x1_in    = cursor_x_ff + adv16;
                  print_in = 1'b1;
               end
            endcase
            state_in = S_CURS;
         end
         S_CURS: begin
            cursor_x_in = x2;
            cursor_y_in = clear_hit ? '0 : y2;
            clr_in      = clear_hit;
            if (print_ff && (height != '0)) begin
               state_in = S_ROWS;
            end else if (clear_hit) begin
               state_in = S_CLEAR;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ROWS: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = off_ff;
               rsp_mask_in   = font_rd_data_ff;
               rsp_color_in  = text_color_ff;
               rsp_clear_in  = 1'b0;
               rsp_last_in   = last_row && !clr_ff;
               off_in        = off_ff + OFFSET_W'(line_stride_ff);
               if (last_row) begin
                  row_in   = '0;
                  state_in = clr_ff ? S_CLEAR : S_IDLE;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
         end
         S_CLEAR: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = '0;
               rsp_mask_in   = '0;
               rsp_color_in  = '0;
               rsp_clear_in  = 1'b1;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         text_color_ff    <= RST_TEXT_COLOR;
         line_stride_ff   <= RST_LINE_STRIDE;
         screen_width_ff  <= RST_SCREEN_WIDTH;
         screen_height_ff <= RST_SCREEN_HEIGHT;
         glyph_advance_ff <= RST_GLYPH_ADVANCE;
         glyph_rows_ff    <= RST_GLYPH_ROWS;
         cursor_x_ff      <= '0;
         cursor_y_ff      <= '0;
         row_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         text_color_ff    <= text_color_in;
         line_stride_ff   <= line_stride_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         glyph_advance_ff <= glyph_advance_in;
         glyph_rows_ff    <= glyph_rows_in;
         cursor_x_ff      <= cursor_x_in;
         cursor_y_ff      <= cursor_y_in;
         row_ff           <= row_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff         <= x1_in;
      y1_ff         <= y1_in;
      code_ff       <= code_in;
      glyph_ff      <= glyph_in;
      print_ff      <= print_in;
      clr_ff        <= clr_in;
      off_ff        <= off_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_clear_ff  <= rsp_clear_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pixel_offset = rsp_offset_ff;
   assign rsp_bus.row_mask     = rsp_mask_ff;
   assign rsp_bus.pixel_color  = rsp_color_ff;
   assign rsp_bus.clear_screen = rsp_clear_ff;
   assign rsp_bus.last         = rsp_last_ff;

   `TCGR_ASSERT_IMP(a_clear_is_last, clock, reset, rsp_valid_ff && rsp_clear_ff,
      rsp_last_ff && (rsp_mask_ff == '0), "clear request not final or has a mask")
   `TCGR_ASSERT_IMP(a_row_in_range, clock, reset, state_ff == S_ROWS,
      HEIGHT_W'(row_ff) < height, "glyph row counter beyond glyph height")
   `TCGR_ASSERT_NXT(a_cursor_x_wrapped, clock, reset, state_ff == S_CURS,
      (cursor_x_ff < CURSOR_W'(screen_width_ff)) || (cursor_x_ff == '0),
      "cursor x left beyond screen width")
   `TCGR_ASSERT_NXT(a_cursor_y_cleared, clock, reset, state_ff == S_CURS,
      (cursor_y_ff < CURSOR_W'(screen_height_ff)) || (cursor_y_ff == '0),
      "cursor y left beyond screen height")
   `TCGR_ASSERT_IMP(a_font_write_idle, clock, reset, font_wr_en,
      state_ff == S_IDLE, "font write outside idle")

endmodule

`default_nettype wire

@@ tb/text_console_glyph_renderer_test.sv @@
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_test
// Self-checking bench for the glyph renderer. Loads a small font, prints
// directed control and glyph sequences, then random character streams under
// a series of screen geometries including both range extremes. A scoreboard
// class tracks the cursor, font and registers, predicts every glyph row and
// clear request, and checks the results in order while the request side
// bursts and the result side stalls.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_test;
   import tcgr_pkg::*;

   localparam int LIMIT_CYCLES     = 500000;
   localparam int DRAIN_CYCLES     = 40;
   localparam int HOLD_CYCLES      = 400;
   localparam int RANDOM_PER_PHASE = 38;
   localparam int PHASES           = 7;
   localparam int MAX_ROWS         = 16;

   typedef struct {
      logic                  mode;
      logic [CODE_W-1:0]     code;
      logic [FONT_ROW_W-1:0] row;
      logic [7:0]            bits;
      logic                  eos;
   } char_request_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [7:0]          mask;
      logic [COLOR_W-1:0]  color;
      logic                clear;
      logic                last;
   } glyph_row_type;

   class glyph_scoreboard_type;
      logic [COLOR_W-1:0]   text_color;
      logic [STRIDE_W-1:0]  line_stride;
      logic [SCREEN_W-1:0]  screen_width;
      logic [SCREEN_W-1:0]  screen_height;
      logic [ADVANCE_W-1:0] glyph_advance;
      logic [ROWS_W-1:0]    glyph_rows;
      logic [CURSOR_W-1:0]  cursor_x;
      logic [CURSOR_W-1:0]  cursor_y;
      logic [7:0]           font_mem [0:4095];
      glyph_row_type        expected_rows [$];
      int                   errors;

      function new();
         text_color    = RST_TEXT_COLOR;
         line_stride   = RST_LINE_STRIDE;
         screen_width  = RST_SCREEN_WIDTH;
         screen_height = RST_SCREEN_HEIGHT;
         glyph_advance = RST_GLYPH_ADVANCE;
         glyph_rows    = RST_GLYPH_ROWS;
         cursor_x      = '0;
         cursor_y      = '0;
         errors        = 0;
      endfunction

      function int unsigned height();
         return (glyph_rows < MAX_ROWS) ? glyph_rows : MAX_ROWS;
      endfunction

      function void set_reg(tcgr_csr_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_TEXT_COLOR:    text_color    = v[COLOR_W-1:0];
            CSR_LINE_STRIDE:   line_stride   = v[STRIDE_W-1:0];
            CSR_SCREEN_WIDTH:  screen_width  = v[SCREEN_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height = v[SCREEN_W-1:0];
            CSR_GLYPH_ADVANCE: glyph_advance = v[ADVANCE_W-1:0];
            CSR_GLYPH_ROWS:    glyph_rows    = v[ROWS_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_request(char_request_type rq);
         logic [31:0]   x, y, h, adv, r;
         logic [63:0]   off;
         int            produced;
         glyph_row_type e;
         x        = cursor_x;
         y        = cursor_y;
         h        = height();
         adv      = glyph_advance;
         produced = 0;
         if (rq.mode) begin
            font_mem[{rq.code, rq.row}] = rq.bits;
            return;
         end
         case (rq.code)
            CODE_LF: begin
               y = (y + h) & 32'hFFFF;
               x = 0;
            end
            CODE_CR: x = 0;
            CODE_TAB: x = (x + adv * 3) & 32'hFFFF;
            CODE_BS: begin
               if (x < adv) begin
                  x = (screen_width - adv) & 32'hFFFF;
                  y = (y - h) & 32'hFFFF;
               end else begin
                  x = x - adv;
               end
            end
            default: begin
               for (r = 0; r < h; r++) begin
                  off      = x + (y + r) * line_stride;
                  e.offset = off[OFFSET_W-1:0];
                  e.mask   = font_mem[{rq.code, r[3:0]}];
                  e.color  = text_color;
                  e.clear  = 1'b0;
                  e.last   = 1'b0;
                  expected_rows.push_back(e);
                  produced++;
               end
               x = (x + adv) & 32'hFFFF;
            end
         endcase
         if (x >= screen_width) begin
            x = 0;
            y = (y + h) & 32'hFFFF;
         end
         if (y >= screen_height) begin
            e = '{offset: '0, mask: '0, color: '0, clear: 1'b1, last: 1'b0};
            expected_rows.push_back(e);
            produced++;
            y = 0;
         end
         cursor_x = x[CURSOR_W-1:0];
         cursor_y = y[CURSOR_W-1:0];
         if (produced > 0) expected_rows[expected_rows.size()-1].last = 1'b1;
      endfunction

      function void check_row(glyph_row_type got);
         glyph_row_type e;
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected result offset %h mask %h color %h clear %b last %b",
                     $time, got.offset, got.mask, got.color, got.clear, got.last);
            errors++;
            return;
         end
         e = expected_rows.pop_front();
         if (got !== e) begin
            $display("%0t: result mismatch expected offset %h mask %h color %h clear %b last %b",
                     $time, e.offset, e.mask, e.color, e.clear, e.last);
            $display("%0t:                 actual   offset %h mask %h color %h clear %b last %b",
                     $time, got.offset, got.mask, got.color, got.clear, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tcgr_req_if req_bus ();
   tcgr_rsp_if rsp_bus ();

   text_console_glyph_renderer dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   glyph_scoreboard_type sb;
   logic [15:0]     rows_loaded [0:255];
   logic [7:0]      font_pool [0:7] = '{8'h41, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h20};
   logic [7:0]      control_codes [0:3] = '{CODE_BS, CODE_TAB, CODE_LF, CODE_CR};
   int              burst_left = 0;
   int              cycle_count = 0;
   bit              hold_wanted = 0;
   bit              hold_done = 0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("text_console_glyph_renderer verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin : result_monitor
      glyph_row_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.offset = rsp_bus.pixel_offset;
         got.mask   = rsp_bus.row_mask;
         got.color  = rsp_bus.pixel_color;
         got.clear  = rsp_bus.clear_screen;
         got.last   = rsp_bus.last;
         sb.check_row(got);
      end
   end

   // result side stall pattern, with one long hold-off
   initial begin : result_stalls
      int mode, len, k;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_wanted && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1;
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(1, 60);
         for (k = 0; k < len; k++) begin
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= k[0];
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic offer(input char_request_type rq);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= rq.mode;
      req_bus.char_code     <= rq.code;
      req_bus.font_row      <= rq.row;
      req_bus.font_bits     <= rq.bits;
      req_bus.end_of_string <= rq.eos;
      do @(posedge clock); while (!req_bus.ready);
      sb.take_request(rq);
   endtask

   task automatic send_char(input logic [7:0] code);
      char_request_type rq;
      rq = '{mode: 1'b0, code: code, row: FONT_ROW_W'($urandom), bits: 8'($urandom),
             eos: 1'($urandom_range(0, 1))};
      offer(rq);
   endtask

   task automatic next_random(output char_request_type rq);
      int          pick, tries, h;
      logic [7:0]  g;
      logic [15:0] need;
      rq.mode = 1'b0;
      rq.row  = FONT_ROW_W'($urandom);
      rq.bits = 8'($urandom);
      rq.eos  = 1'($urandom_range(0, 1));
      pick    = $urandom_range(0, 99);
      if (pick < 15) begin
         rq.mode = 1'b1;
         rq.code = $urandom_range(0, 1) ? font_pool[$urandom_range(0, 7)] : 8'($urandom);
         rows_loaded[rq.code][rq.row] = 1'b1;
      end else if (pick < 30) begin
         rq.code = control_codes[$urandom_range(0, 3)];
      end else begin
         // only glyphs whose visible rows were all loaded
         rq.code = CODE_CR;
         h       = sb.height();
         need    = (h >= 16) ? 16'hFFFF : ((16'h1 << h) - 16'h1);
         for (tries = 0; tries < 16; tries++) begin
            g = (tries < 8 && $urandom_range(0, 2) != 0) ? font_pool[$urandom_range(0, 7)]
                                                          : 8'($urandom);
            if ((rows_loaded[g] & need) == need) begin
               rq.code = g;
               break;
            end
         end
      end
   endtask

   task automatic write_reg(input tcgr_csr_type idx, input logic [31:0] v, input int w);
      logic [31:0] data;
      data = v;
      if (w < 32) data = v | ($urandom << w);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic write_geometry(input logic [31:0] color, input int stride, input int width,
                                 input int height, input int adv, input int rows);
      write_reg(CSR_TEXT_COLOR, color, COLOR_W);
      write_reg(CSR_LINE_STRIDE, stride, STRIDE_W);
      write_reg(CSR_SCREEN_WIDTH, width, SCREEN_W);
      write_reg(CSR_SCREEN_HEIGHT, height, SCREEN_W);
      write_reg(CSR_GLYPH_ADVANCE, adv, ADVANCE_W);
      write_reg(CSR_GLYPH_ROWS, rows, ROWS_W);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.expected_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      char_request_type rq;
      int               p, i, g, r;
      logic [7:0]       basic_codes [0:14];
      basic_codes = '{8'h41, 8'h00, 8'hFF, 8'h80, 8'h7F, CODE_TAB, CODE_BS, CODE_CR, CODE_LF,
                      CODE_BS, 8'h41, CODE_CR, CODE_BS, CODE_CR, CODE_BS};
      clock                 = 1'b0;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.mode          = 1'b0;
      req_bus.char_code     = '0;
      req_bus.font_row      = '0;
      req_bus.font_bits     = '0;
      req_bus.end_of_string = 1'b0;
      sb                    = new();
      for (g = 0; g < 256; g++) rows_loaded[g] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // font setup for the pool glyphs
      for (g = 0; g < 8; g++) begin
         for (r = 0; r < MAX_ROWS; r++) begin
            rq = '{mode: 1'b1, code: font_pool[g], row: FONT_ROW_W'(r), bits: 8'($urandom),
                   eos: 1'($urandom_range(0, 1))};
            rows_loaded[font_pool[g]][r] = 1'b1;
            offer(rq);
         end
      end

      for (p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            drain();
            case (p)
               1: write_geometry(32'h0000_0000, 1, 8, 8, 16, 1);
               2: write_geometry(32'hFFFF_FFFF, 8192, 4096, 4096, 16, 16);
               default: write_geometry($urandom,
                  ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 1 : 8192)
                                              : $urandom_range(1, 8192),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(8, 4096) : $urandom_range(8, 96),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(8, 4096) : $urandom_range(8, 96),
                  $urandom_range(1, 16), $urandom_range(1, 16));
            endcase
         end
         if (p == 0) begin
            for (i = 0; i < 15; i++) send_char(basic_codes[i]);
         end
         if (p == 1) begin
            send_char(CODE_TAB);
            for (i = 0; i < 8; i++) send_char(i[0] ? 8'hAA : 8'h55);
         end
         if (p == 3) hold_wanted = 1;
         for (i = 0; i < RANDOM_PER_PHASE; i++) begin
            next_random(rq);
            offer(rq);
         end
      end
      drain();

      if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
         $display("text_console_glyph_renderer verification clean");
      end else begin
         $display("text_console_glyph_renderer verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tcgr_pkg.sv
rtl/tcgr_req_if.sv
rtl/tcgr_rsp_if.sv
rtl/tcgr_font_ram.sv
rtl/text_console_glyph_renderer.sv
tb/text_console_glyph_renderer_test.sv
